>>> rtl/rvp_pkg.sv
`timescale 1ns / 1ps

package rvp_pkg;

    localparam int RAD_W  = 56;
    localparam int ROOT_W = 28;
    localparam int DIV_W  = 60;
    localparam int QUOT_W = 32;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 32;

    localparam logic [1:0] REG_NUM_BINS = 2'd0;
    localparam logic [1:0] REG_EXTENT   = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    typedef struct packed {
        logic              start;
        logic [RAD_W-1:0]  radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem0;
        logic [DIV_W-1:0]  divisor;
        logic [QUOT_W-1:0] shift;
        logic [5:0]        steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

>>> rtl/rvp_if.sv
`timescale 1ns / 1ps

interface rvp_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [10:0] off_x;
    logic signed [10:0] off_y;
    logic signed [10:0] off_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic        [31:0] density;

    modport source (output valid, func, off_x, off_y, off_z, mom_x, mom_y, mom_z, density,
                    input ready);
    modport sink (input valid, func, off_x, off_y, off_z, mom_x, mom_y, mom_z, density,
                  output ready);
endinterface

interface rvp_out_if;
    logic               valid;
    logic               ready;
    logic        [5:0]  bin_index;
    logic signed [31:0] mean_velocity;
    logic        [31:0] cell_count;
    logic               empty_res;
    logic               last;

    modport source (output valid, bin_index, mean_velocity, cell_count, empty_res, last,
                    input ready);
    modport sink (input valid, bin_index, mean_velocity, cell_count, empty_res, last,
                  output ready);
endinterface

>>> rtl/rvp_sqrt.sv
`timescale 1ns / 1ps

module rvp_sqrt
    import rvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [RAD_W-1:0]  rad_reg;
    logic [31:0]       rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [31:0]       rem_sh;
    logic [31:0]       trial;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg[29:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rad_reg  <= req.radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'(ROOT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

>>> rtl/rvp_div.sv
`timescale 1ns / 1ps

module rvp_div
    import rvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [QUOT_W-1:0] sh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W:0]    rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, sh_reg[QUOT_W-1]};
        ge     = rem_sh >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= req.rem0;
                div_reg  <= req.divisor;
                sh_reg   <= req.shift;
                quot_reg <= '0;
                cnt_reg  <= req.steps - 6'd1;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                sh_reg   <= sh_reg << 1;
                rem_reg  <= ge ? DIV_W'(rem_sh - {1'b0, div_reg}) : DIV_W'(rem_sh);
                quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> rtl/radial_velocity_profile_binner.sv
`timescale 1ns / 1ps

// Radial velocity profile binner. An accumulate item runs two 28-step square roots and
// two divisions (28 and 32 steps, the second skipped when its projection saturates) one
// after the other on a shared root unit and a shared one-bit-per-cycle divider, then a
// read-modify-write of the bin memory (skipped for a zero offset, density or extent times
// radius, or an out-of-range bin). A readout item emits one result per bin in use, using
// the 31-step divider only for a bin neither empty nor saturated and holding while a
// result waits for ready, then sweeps the whole memory to zero. The same sweep runs after
// reset; no item is accepted meanwhile, while configuration writes are taken at any time.

module radial_velocity_profile_binner
    import rvp_pkg::*;
#(
    parameter int MAX_BINS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    rvp_in_if.sink            items,
    rvp_out_if.source         results,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BW = $clog2(MAX_BINS + 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A1, S_A2, S_SQ1, S_DV1, S_SQ2, S_MUL, S_CHK, S_DV2, S_UPD,
        S_RD0, S_RD1, S_RD2, S_EMIT
    } state_t;

    state_t state_reg;

    logic [6:0]  nb_reg;
    logic [3:0]  ext_reg;
    logic [15:0] rad_reg;

    logic signed [10:0] ox_reg, oy_reg, oz_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [31:0]        rho_reg;
    logic [21:0]        d2_reg;
    logic [29:0]        kk_reg;
    logic [19:0]        dd_reg;
    logic signed [44:0] dot_reg;
    logic [ROOT_W-1:0]  s_reg;
    logic [DIV_W-1:0]   m_reg;
    logic [31:0]        mag_reg;
    logic               sat_reg;
    logic               neg_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      clr_reg;
    logic [BW-1:0]      b_reg;
    logic [31:0]        mean_reg;

    logic               ov_reg;
    logic [5:0]         obin_reg;
    logic [31:0]        omean_reg;
    logic [31:0]        ocnt_reg;
    logic               oempty_reg;
    logic               olast_reg;

    logic [SUM_W+CNT_W-1:0] mem [MAX_BINS];
    logic [SUM_W+CNT_W-1:0] rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SUM_W+CNT_W-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    logic signed [SUM_W-1:0] rsum;
    logic [CNT_W-1:0]        rcnt;
    logic [SUM_W-1:0]        rmag;
    logic [43:0]             dmag;
    logic signed [31:0]      vel;
    logic signed [SUM_W:0]   acc;
    logic signed [SUM_W-1:0] acc_sat;
    logic [CNT_W-1:0]        cnt_inc;
    logic [BW-1:0]           nlim;
    logic                    bin_ok;
    logic                    emit_go;

    rvp_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .rsp(sqrt_rsp));
    rvp_div  u_div  (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    always_comb
    begin
        rsum = rdata_reg[SUM_W+CNT_W-1:CNT_W];
        rcnt = rdata_reg[CNT_W-1:0];
        rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);
        dmag = dot_reg[44] ? 44'(-dot_reg) : 44'(dot_reg);
        nlim = (32'(nb_reg) >= MAX_BINS) ? BW'(MAX_BINS) : BW'(nb_reg);
        bin_ok = (div_rsp.quot < 32'(nb_reg)) && (div_rsp.quot < MAX_BINS);
        emit_go = (state_reg == S_EMIT) && (!ov_reg || results.ready);

        if (sat_reg)
            vel = neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            vel = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        acc = (SUM_W+1)'(rsum) + (SUM_W+1)'(vel);
        if (acc > (SUM_W+1)'(49'sh007FFFFFFFFFFF))
            acc_sat = 48'sh7FFFFFFFFFFF;
        else if (acc < -(SUM_W+1)'(49'sh00800000000000))
            acc_sat = 48'sh800000000000;
        else
            acc_sat = SUM_W'(acc);
        cnt_inc = (rcnt == '1) ? rcnt : rcnt + 1'b1;

        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = {acc_sat, cnt_inc};
        if (state_reg == S_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_UPD)
        begin
            mem_we = 1'b1;
        end

        mem_re    = 1'b0;
        mem_raddr = b_reg[AW-1:0];
        if (state_reg == S_RD0)
            mem_re = 1'b1;
        else if (state_reg == S_DV1 && div_rsp.done && bin_ok)
        begin
            mem_re    = 1'b1;
            mem_raddr = div_rsp.quot[AW-1:0];
        end

        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = RAD_W'(d2_reg * kk_reg);
        if (state_reg == S_A2 && dd_reg != '0)
            sqrt_req.start = 1'b1;
        else if (state_reg == S_DV1 && div_rsp.done && bin_ok)
        begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = RAD_W'({d2_reg, 32'b0});
        end

        div_req.start   = 1'b0;
        div_req.rem0    = '0;
        div_req.divisor = DIV_W'(dd_reg);
        div_req.shift   = {sqrt_rsp.root, 4'b0};
        div_req.steps   = 6'(ROOT_W);
        if (state_reg == S_SQ1 && sqrt_rsp.done)
            div_req.start = 1'b1;
        else if (state_reg == S_CHK)
        begin
            div_req.start   = !({dmag, 1'b0} >= m_reg);
            div_req.rem0    = DIV_W'(dmag);
            div_req.divisor = m_reg;
            div_req.shift   = '0;
            div_req.steps   = 6'd32;
        end
        else if (state_reg == S_RD1)
        begin
            div_req.start   = (rcnt != '0) && !(63'(rmag) >= {rcnt, 31'b0});
            div_req.rem0    = DIV_W'(rmag[SUM_W-1:31]);
            div_req.divisor = DIV_W'(rcnt);
            div_req.shift   = {rmag[30:0], 1'b0};
            div_req.steps   = 6'd31;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            b_reg     <= '0;
            ov_reg    <= 1'b0;
            nb_reg    <= 7'd16;
            ext_reg   <= 4'd3;
            rad_reg   <= 16'd2560;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_BINS: nb_reg  <= cfg_data[6:0];
                    REG_EXTENT:   ext_reg <= cfg_data[3:0];
                    REG_RADIUS:   rad_reg <= cfg_data;
                    default:      ;
                endcase
            end

            if (emit_go)
                ov_reg <= 1'b1;
            else if (results.ready)
                ov_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    if (clr_reg == AW'(MAX_BINS - 1))
                        state_reg <= S_IDLE;
                    else
                        clr_reg <= clr_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (items.valid)
                    begin
                        ox_reg  <= items.off_x;
                        oy_reg  <= items.off_y;
                        oz_reg  <= items.off_z;
                        px_reg  <= items.mom_x;
                        py_reg  <= items.mom_y;
                        pz_reg  <= items.mom_z;
                        rho_reg <= items.density;
                        b_reg   <= '0;
                        clr_reg <= '0;
                        if (!items.func)
                            state_reg <= S_A1;
                        else if (nlim == '0)
                            state_reg <= S_CLR;
                        else
                            state_reg <= S_RD0;
                    end
                end
                S_A1:
                begin
                    d2_reg  <= 22'(ox_reg * ox_reg) + 22'(oy_reg * oy_reg)
                               + 22'(oz_reg * oz_reg);
                    kk_reg  <= {14'(nb_reg * nb_reg), 16'b0};
                    dd_reg  <= ext_reg * rad_reg;
                    dot_reg <= 45'(px_reg * ox_reg) + 45'(py_reg * oy_reg)
                               + 45'(pz_reg * oz_reg);
                    if ((ox_reg == '0 && oy_reg == '0 && oz_reg == '0) || rho_reg == '0)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_A2;
                end
                S_A2:
                begin
                    neg_reg <= dot_reg[44];
                    state_reg <= (dd_reg == '0) ? S_IDLE : S_SQ1;
                end
                S_SQ1:
                begin
                    if (sqrt_rsp.done)
                        state_reg <= S_DV1;
                end
                S_DV1:
                begin
                    if (div_rsp.done)
                    begin
                        addr_reg  <= div_rsp.quot[AW-1:0];
                        state_reg <= bin_ok ? S_SQ2 : S_IDLE;
                    end
                end
                S_SQ2:
                begin
                    if (sqrt_rsp.done)
                    begin
                        s_reg     <= sqrt_rsp.root;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    m_reg     <= DIV_W'(rho_reg * s_reg);
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    sat_reg <= {dmag, 1'b0} >= m_reg;
                    state_reg <= ({dmag, 1'b0} >= m_reg) ? S_UPD : S_DV2;
                end
                S_DV2:
                begin
                    if (div_rsp.done)
                    begin
                        mag_reg   <= div_rsp.quot;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    state_reg <= S_IDLE;
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    neg_reg <= rsum[SUM_W-1];
                    if (rcnt == '0)
                    begin
                        mean_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (63'(rmag) >= {rcnt, 31'b0})
                    begin
                        mean_reg  <= rsum[SUM_W-1] ? 32'h80000000 : 32'h7FFFFFFF;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RD2;
                    end
                end
                S_RD2:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg  <= neg_reg ? -div_rsp.quot : div_rsp.quot;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        obin_reg   <= 6'(b_reg);
                        omean_reg  <= mean_reg;
                        ocnt_reg   <= rcnt;
                        oempty_reg <= (rcnt == '0);
                        olast_reg  <= (b_reg == BW'(nlim - 1'b1));
                        if (b_reg == BW'(nlim - 1'b1))
                            state_reg <= S_CLR;
                        else
                        begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= S_RD0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign items.ready           = (state_reg == S_IDLE);
    assign results.valid         = ov_reg;
    assign results.bin_index     = obin_reg;
    assign results.mean_velocity = omean_reg;
    assign results.cell_count    = ocnt_reg;
    assign results.empty_res     = oempty_reg;
    assign results.last          = olast_reg;

    a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !items.ready)
        else $error("item accepted during clearing sweep");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |=> state_reg == S_IDLE)
        else $error("update did not return to idle");

endmodule
